// ===== hw/rtl/pi_controller_clamped_unit_macros.svh =====
// Assertion macros for the clamped PI regulator.
// Used by pi_controller_clamped_unit; expects signals clk and rst_n in scope.
`ifndef PI_CONTROLLER_CLAMPED_UNIT_MACROS_SVH
`define PI_CONTROLLER_CLAMPED_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PIC_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PIC_ASSERT_NXT(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/pic_pkg.sv =====
// Shared types and constants of the clamped PI regulator.
// No dependencies; imported by pi_controller_clamped_unit.
`timescale 1ns / 1ps

package pic_pkg;

    // Field widths of the Q16.16 datapath.
    localparam int DATA_W    = 32;
    localparam int PERIOD_W  = 31;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] q16_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND     = 3'd5;

    // Item operation codes.
    localparam logic OP_COMPUTE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    // Reset values of the limits and dead band (dead band is about 0.0001).
    localparam q16_t                OUT_MAX_RST   = 32'sh7FFF_FFFF;
    localparam q16_t                OUT_MIN_RST   = 32'sh8000_0000;
    localparam logic [PERIOD_W-1:0] DEAD_BAND_RST = 31'd7;

    // Serial multiplier: one multiplier bit per cycle, sign bit last.
    localparam logic [4:0] MUL_LAST = 5'd31;

    // Saturate a 50-bit signed value to signed 32 bits.
    function automatic q16_t sat_q16(input logic signed [49:0] x);
        q16_t y;
        if (!x[49] && (|x[48:31])) begin
            y = OUT_MAX_RST;
        end else if (x[49] && !(&x[48:31])) begin
            y = OUT_MIN_RST;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

// ===== hw/rtl/pi_controller_clamped_unit.sv =====
// Clamped PI regulator in signed Q16.16, with a bit-serial shared multiplier.
// Depends on pic_pkg and pi_controller_clamped_unit_macros.svh.
`timescale 1ns / 1ps
`include "pi_controller_clamped_unit_macros.svh"

// Usage:
// Configuration writes come on the cfg channel (index, data); cfg_ready is
// always high and a write takes effect at the accepting edge. Write only while
// the block is idle. An input item carries op, reference, action_in and
// measured; every item gives exactly one result item (drive, clamped).
// A compute item runs three shift-add multiplications (T*e, Ki*s, Kp*e) on
// one shared serial multiplier together with the steps SAT, DB, RND_S, RND_I,
// CAND, RND_P, SUM_U and LIMIT; its result is loaded at the same edge at which
// in_ready rises again, so no new item is taken while one is in work. A clear
// item zeroes the integrator and produces drive = 0.
// The result sits in an output register; a new item is taken while it
// waits. If the receiver stalls, the next result holds in the final step
// until the output register is free, and no item is taken meanwhile.
// Reset clears the integrator, the output register and the control state
// and restores register defaults (limits at full range, dead band 7).
module pi_controller_clamped_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pic_pkg::DATA_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             op,
    input  pic_pkg::q16_t                    reference,
    input  pic_pkg::q16_t                    action_in,
    input  pic_pkg::q16_t                    measured,
    output logic                             out_valid,
    input  logic                             out_ready,
    output pic_pkg::q16_t                    drive,
    output logic                             clamped
);
    import pic_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAT,
        ST_DB,
        ST_MUL_TE,
        ST_RND_S,
        ST_MUL_KS,
        ST_RND_I,
        ST_CAND,
        ST_MUL_KE,
        ST_RND_P,
        ST_SUM_U,
        ST_LIMIT,
        ST_CLEAR
    } state_t;

    // Configuration registers.
    q16_t                gain_prop_reg;
    q16_t                gain_integ_reg;
    logic [PERIOD_W-1:0] period_reg;
    q16_t                out_max_reg;
    q16_t                out_min_reg;
    logic [PERIOD_W-1:0] dead_band_reg;

    // Control state and output register.
    state_t     state_reg, state_next;
    logic [4:0] bit_cnt_reg, bit_cnt_next;
    logic       out_valid_reg, out_valid_next;
    q16_t       drive_reg, drive_next;
    logic       clamped_reg, clamped_next;
    q16_t       integ_reg, integ_next;

    // Datapath registers.
    logic signed [33:0] sum_reg, sum_next;
    q16_t               e_reg, e_next;
    logic signed [32:0] mcand_reg, mcand_next;
    logic [31:0]        mplier_reg, mplier_next;
    logic signed [32:0] hi_reg, hi_next;
    logic [31:0]        lo_reg, lo_next;
    logic signed [48:0] inc_reg, inc_next;
    q16_t               cand_reg, cand_next;
    logic signed [48:0] pe_reg, pe_next;
    logic signed [49:0] u_reg, u_next;

    // Combinational helpers.
    logic signed [33:0] mcand_ext;
    logic signed [33:0] mul_addend;
    logic signed [33:0] mul_sum;
    logic signed [48:0] rnd_val;
    q16_t               e_sat;
    logic [32:0]        e_mag;
    q16_t               e_db;
    logic signed [49:0] max_ext;
    logic signed [49:0] min_ext;
    logic               res_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

    // Configuration write decoder; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg  <= '0;
            gain_integ_reg <= '0;
            period_reg     <= '0;
            out_max_reg    <= OUT_MAX_RST;
            out_min_reg    <= OUT_MIN_RST;
            dead_band_reg  <= DEAD_BAND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN_PROP:     gain_prop_reg  <= cfg_data;
                REG_GAIN_INTEG:    gain_integ_reg <= cfg_data;
                REG_SAMPLE_PERIOD: period_reg     <= cfg_data[PERIOD_W-1:0];
                REG_OUTPUT_MAX:    out_max_reg    <= cfg_data;
                REG_OUTPUT_MIN:    out_min_reg    <= cfg_data;
                REG_DEAD_BAND:     dead_band_reg  <= cfg_data[PERIOD_W-1:0];
                default:           ;
            endcase
        end
    end

    // Serial multiplier step: add or subtract the multiplicand, shift right.
    // The last (sign) bit of the multiplier carries negative weight.
    assign mcand_ext  = {mcand_reg[32], mcand_reg};
    assign mul_addend = !mplier_reg[0] ? 34'sd0 :
                        (bit_cnt_reg == MUL_LAST) ? -mcand_ext : mcand_ext;
    assign mul_sum    = {hi_reg[32], hi_reg} + mul_addend;

    // Q32.32 to Q16.16, round half up: floor(p / 2^16) plus bit 15 of p.
    assign rnd_val = $signed({hi_reg, lo_reg[31:16]}) + $signed({48'd0, lo_reg[15]});

    // Error saturation and dead band.
    assign e_sat = sat_q16({{16{sum_reg[33]}}, sum_reg});
    assign e_mag = e_reg[31] ? (33'd0 - {1'b1, e_reg}) : {1'b0, e_reg};
    assign e_db  = (e_mag < {2'b00, dead_band_reg}) ? '0 : e_reg;

    // Limits widened to the output sum.
    assign max_ext = {{18{out_max_reg[31]}}, out_max_reg};
    assign min_ext = {{18{out_min_reg[31]}}, out_min_reg};

    // A result moves into the output register when that register is free.
    assign res_load = ((state_reg == ST_LIMIT) || (state_reg == ST_CLEAR)) &&
                      (!out_valid_reg || out_ready);

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg;
        drive_next     = drive_reg;
        clamped_next   = clamped_reg;
        integ_next     = integ_reg;
        sum_next       = sum_reg;
        e_next         = e_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        inc_next       = inc_reg;
        cand_next      = cand_reg;
        pe_next        = pe_reg;
        u_next         = u_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sum_next = {{2{reference[31]}}, reference}
                             + {{2{action_in[31]}}, action_in}
                             - {{2{measured[31]}}, measured};
                    state_next = (op == OP_CLEAR) ? ST_CLEAR : ST_SAT;
                end
            end
            ST_SAT:
            begin
                e_next     = e_sat;
                state_next = ST_DB;
            end
            ST_DB:
            begin
                e_next       = e_db;
                mplier_next  = e_db;
                mcand_next   = {2'b00, period_reg};
                hi_next      = '0;
                bit_cnt_next = '0;
                state_next   = ST_MUL_TE;
            end
            ST_MUL_TE, ST_MUL_KS, ST_MUL_KE:
            begin
                hi_next      = mul_sum[33:1];
                lo_next      = {mul_sum[0], lo_reg[31:1]};
                mplier_next  = {1'b0, mplier_reg[31:1]};
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == MUL_LAST)
                begin
                    if (state_reg == ST_MUL_TE)
                    begin
                        state_next = ST_RND_S;
                    end
                    else if (state_reg == ST_MUL_KS)
                    begin
                        state_next = ST_RND_I;
                    end
                    else
                    begin
                        state_next = ST_RND_P;
                    end
                end
            end
            ST_RND_S:
            begin
                mplier_next  = sat_q16({rnd_val[48], rnd_val});
                mcand_next   = {gain_integ_reg[31], gain_integ_reg};
                hi_next      = '0;
                bit_cnt_next = '0;
                state_next   = ST_MUL_KS;
            end
            ST_RND_I:
            begin
                inc_next   = rnd_val;
                state_next = ST_CAND;
            end
            ST_CAND:
            begin
                cand_next    = sat_q16({{18{integ_reg[31]}}, integ_reg}
                                       + {inc_reg[48], inc_reg});
                mplier_next  = e_reg;
                mcand_next   = {gain_prop_reg[31], gain_prop_reg};
                hi_next      = '0;
                bit_cnt_next = '0;
                state_next   = ST_MUL_KE;
            end
            ST_RND_P:
            begin
                pe_next    = rnd_val;
                state_next = ST_SUM_U;
            end
            ST_SUM_U:
            begin
                u_next     = {pe_reg[48], pe_reg} + {{18{cand_reg[31]}}, cand_reg};
                state_next = ST_LIMIT;
            end
            ST_LIMIT:
            begin
                // Clamp; the integrator only advances on an unclamped step.
                if (res_load)
                begin
                    out_valid_next = 1'b1;
                    if (u_reg > max_ext)
                    begin
                        drive_next   = out_max_reg;
                        clamped_next = 1'b1;
                    end
                    else if (u_reg < min_ext)
                    begin
                        drive_next   = out_min_reg;
                        clamped_next = 1'b1;
                    end
                    else
                    begin
                        drive_next   = u_reg[31:0];
                        clamped_next = 1'b0;
                        integ_next   = cand_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (res_load)
                begin
                    out_valid_next = 1'b1;
                    drive_next     = '0;
                    clamped_next   = 1'b0;
                    integ_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, integrator and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
            clamped_reg   <= 1'b0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
            drive_reg     <= drive_next;
            clamped_reg   <= clamped_next;
            integ_reg     <= integ_next;
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        e_reg      <= e_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        inc_reg    <= inc_next;
        cand_reg   <= cand_next;
        pe_reg     <= pe_next;
        u_reg      <= u_next;
    end

    // The multiplier bit counter advances by one through every serial pass.
    `PIC_ASSERT_NXT(a_mul_count,
        (((state_reg == ST_MUL_TE) || (state_reg == ST_MUL_KS) ||
          (state_reg == ST_MUL_KE)) && (bit_cnt_reg != MUL_LAST)),
        (bit_cnt_reg == ($past(bit_cnt_reg) + 5'd1)),
        "serial multiplier count skipped")

    // A clear item leaves a zero integrator and a zero, unclamped result.
    `PIC_ASSERT_NXT(a_clear_result,
        ((state_reg == ST_CLEAR) && res_load),
        ((integ_reg == '0) && (drive_reg == '0) && !clamped_reg && out_valid_reg),
        "clear item did not zero the integrator and result")

    // The integrator only changes when a result is loaded.
    `PIC_ASSERT_NXT(a_integ_hold,
        (!res_load),
        $stable(integ_reg),
        "integrator changed outside a result load")

endmodule

// ===== sim/tb_pi_controller_clamped_unit.sv =====
// Self-checking testbench for the clamped PI regulator (pi_controller_clamped_unit).
// Depends on pic_pkg and the RTL; stimulus, idling and result prediction are all built in.
`timescale 1ns / 1ps

module tb_pi_controller_clamped_unit;

    import pic_pkg::*;

    // Spare register indexes that the block must ignore.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Handy Q16.16 values.
    localparam q16_t Q_ONE = 32'sh0001_0000;
    localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q_MIN = 32'sh8000_0000;

    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        q16_t drive;
        logic clamped;
    } drive_result_t;

    // Block ports.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 op = OP_COMPUTE;
    q16_t                 reference = '0;
    q16_t                 action_in = '0;
    q16_t                 measured = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    q16_t                 drive;
    logic                 clamped;

    // Predicted register contents and integrator.
    q16_t                kp_cfg = '0;
    q16_t                ki_cfg = '0;
    logic [PERIOD_W-1:0] period_cfg = '0;
    q16_t                max_cfg = Q_MAX;
    q16_t                min_cfg = Q_MIN;
    logic [PERIOD_W-1:0] dband_cfg = 31'd7;
    q16_t                integ_model = '0;

    drive_result_t result_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatch_cnt = 0;
    int items_sent = 0;
    int clears_sent = 0;
    int cfg_writes = 0;
    int results_seen = 0;
    int clamped_seen = 0;

    pi_controller_clamped_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .reference (reference),
        .action_in (action_in),
        .measured  (measured),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .clamped   (clamped)
    );

    // Clock generation.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Saturate to the signed 32-bit range.
    function automatic longint sat32(longint x);
        if (x > longint'(Q_MAX))
            return longint'(Q_MAX);
        if (x < longint'(Q_MIN))
            return longint'(Q_MIN);
        return x;
    endfunction

    // Scale a Q32.32 product to Q16.16, rounding half toward +infinity.
    function automatic longint rnd_q16(longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    // One regulator step: returns the expected result and advances the integrator.
    function automatic drive_result_t predict_step(logic op_v, q16_t r, q16_t a, q16_t m);
        drive_result_t res;
        longint        err;
        longint        mag;
        longint        scaled;
        longint        cand;
        longint        u;
        if (op_v == OP_CLEAR)
        begin
            integ_model = '0;
            res.drive = '0;
            res.clamped = 1'b0;
            return res;
        end
        err = sat32(longint'(r) + longint'(a) - longint'(m));
        mag = (err < 0) ? -err : err;
        if (mag < longint'({33'd0, dband_cfg}))
            err = 0;
        scaled = sat32(rnd_q16(longint'({33'd0, period_cfg}) * err));
        cand = sat32(longint'(integ_model) + rnd_q16(longint'(ki_cfg) * scaled));
        u = rnd_q16(longint'(kp_cfg) * err) + cand;
        // Upper limit is tested first, so inverted limits favor output_max.
        if (u > longint'(max_cfg))
        begin
            res.drive = max_cfg;
            res.clamped = 1'b1;
        end
        else if (u < longint'(min_cfg))
        begin
            res.drive = min_cfg;
            res.clamped = 1'b1;
        end
        else
        begin
            res.drive = u[31:0];
            res.clamped = 1'b0;
            integ_model = cand[31:0];
        end
        return res;
    endfunction

    // Count a failure; only the first few are printed.
    task automatic note_mismatch(string what, longint want_v, longint got_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("Mismatch on %s at %0t: expected %0d, got %0d", what, $time, want_v, got_v);
    endtask

    // Write one register and mirror it in the predictor; valid stays high afterwards.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_GAIN_PROP:     kp_cfg = data;
            REG_GAIN_INTEG:    ki_cfg = data;
            REG_SAMPLE_PERIOD: period_cfg = data[PERIOD_W-1:0];
            REG_OUTPUT_MAX:    max_cfg = data;
            REG_OUTPUT_MIN:    min_cfg = data;
            REG_DEAD_BAND:     dband_cfg = data[PERIOD_W-1:0];
            default:           ;
        endcase
        cfg_writes++;
    endtask

    // Write the full register set, plus a spare index that must have no effect.
    task automatic apply_config(q16_t kp, q16_t ki, logic [DATA_W-1:0] t_raw,
                                q16_t omax, q16_t omin, logic [DATA_W-1:0] db_raw);
        cfg_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        cfg_write(REG_GAIN_PROP, kp);
        cfg_write(REG_GAIN_INTEG, ki);
        cfg_write(REG_SAMPLE_PERIOD, t_raw);
        cfg_write(REG_OUTPUT_MAX, omax);
        cfg_write(REG_OUTPUT_MIN, omin);
        cfg_write(REG_DEAD_BAND, db_raw);
        cfg_valid <= 1'b0;
    endtask

    // Offer one item, wait for it to be taken, and queue its expected result.
    task automatic send_item(logic op_v, q16_t r, q16_t a, q16_t m);
        drive_result_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= op_v;
        reference <= r;
        action_in <= a;
        measured <= m;
        do @(posedge clk); while (!in_ready);
        want = predict_step(op_v, r, a, m);
        result_q.push_back(want);
        items_sent++;
        if (op_v == OP_CLEAR)
            clears_sent++;
    endtask

    // Stop offering items and wait until every expected result has arrived.
    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (result_q.size() != 0);
    endtask

    // Mostly small signed values, sometimes full-range words or edge values.
    function automatic q16_t rand_q16();
        case ($urandom_range(9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'sd1;
                    3: return -32'sd1;
                    default: return '0;
                endcase
            end
            default: return int'($urandom_range(0, 2097152)) - 1048576;
        endcase
    endfunction

    // Random compute or clear item; some computes sit right on the dead-band edge.
    task automatic send_random_item();
        int   roll;
        q16_t r;
        q16_t a;
        q16_t m;
        q16_t db;
        roll = $urandom_range(99);
        r = rand_q16();
        a = rand_q16();
        m = rand_q16();
        db = {1'b0, dband_cfg};
        if (roll < 10)
        begin
            send_item(OP_CLEAR, $urandom, $urandom, $urandom);
        end
        else
        begin
            if (roll < 22)
            begin
                case ($urandom_range(3))
                    0: m = r + a - db;
                    1: m = r + a - (db - 32'sd1);
                    2: m = r + a + db;
                    default: m = r + a + (db - 32'sd1);
                endcase
            end
            send_item(OP_COMPUTE, r, a, m);
        end
    endtask

    // Pick a register set: mostly moderate gains and limits, sometimes extremes.
    task automatic randomize_config();
        q16_t             kp;
        q16_t             ki;
        q16_t             omax;
        q16_t             omin;
        q16_t             swap;
        logic [DATA_W-1:0] t_raw;
        logic [DATA_W-1:0] db_raw;
        case ($urandom_range(9))
            0:
            begin
                kp = $urandom;
                ki = $urandom;
                t_raw = $urandom;
                omax = $urandom;
                omin = $urandom;
                db_raw = $urandom;
            end
            1:
            begin
                kp = $urandom_range(1) ? Q_MAX : Q_MIN;
                ki = $urandom_range(1) ? Q_MAX : Q_MIN;
                t_raw = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                omax = $urandom_range(1) ? Q_MAX : Q_ONE;
                omin = $urandom_range(1) ? Q_MIN : -Q_ONE;
                db_raw = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            end
            default:
            begin
                kp = int'($urandom_range(0, 524288)) - 262144;
                ki = int'($urandom_range(0, 524288)) - 262144;
                t_raw = $urandom_range(0, 6554);
                omax = $urandom_range(0, 67108864);
                omin = -int'($urandom_range(0, 67108864));
                db_raw = $urandom_range(0, 2000);
                // Now and then the limits come in the wrong order.
                if ($urandom_range(7) == 0)
                begin
                    swap = omax;
                    omax = omin;
                    omin = swap;
                end
            end
        endcase
        apply_config(kp, ki, t_raw, omax, omin, db_raw);
    endtask

    // After reset all gains are zero, so every compute item yields zero drive.
    task automatic test_reset_defaults();
        send_item(OP_COMPUTE, Q_MAX, Q_MAX, Q_MIN);
        send_item(OP_COMPUTE, Q_MIN, Q_MIN, Q_MAX);
        send_item(OP_CLEAR, Q_MAX, Q_MIN, '0);
        wait_drain();
    endtask

    // Errors around the dead band, then a wind-up into both limits and a clear.
    task automatic test_dead_band_and_clamp();
        apply_config(Q_ONE, Q_ONE, Q_ONE, 100 * Q_ONE, -100 * Q_ONE, 32'd7);
        send_item(OP_COMPUTE, 32'sd6, '0, '0);
        send_item(OP_COMPUTE, '0, 32'sd7, '0);
        send_item(OP_COMPUTE, '0, '0, 32'sd7);
        send_item(OP_COMPUTE, '0, '0, 32'sd6);
        send_item(OP_COMPUTE, 50 * Q_ONE, '0, '0);
        send_item(OP_COMPUTE, 50 * Q_ONE, '0, '0);
        send_item(OP_COMPUTE, '0, '0, 300 * Q_ONE);
        send_item(OP_CLEAR, Q_ONE, Q_ONE, Q_ONE);
        wait_drain();
    endtask

    // Minimum above maximum: the upper test wins, then the lower one.
    task automatic test_inverted_limits();
        apply_config(Q_ONE, Q_ONE, Q_ONE, -10 * Q_ONE, 10 * Q_ONE, 32'd7);
        send_item(OP_COMPUTE, '0, '0, '0);
        send_item(OP_COMPUTE, '0, '0, 50 * Q_ONE);
        wait_drain();
    endtask

    // Full-scale gains, period and dead band, with bits above the 31-bit fields set.
    task automatic test_extreme_config();
        apply_config(Q_MAX, Q_MIN, 32'hFFFF_FFFF, Q_MAX, Q_MIN, 32'hFFFF_FFFF);
        send_item(OP_COMPUTE, Q_MAX, Q_MAX, Q_MIN);
        send_item(OP_COMPUTE, Q_MIN, Q_MIN, Q_MAX);
        send_item(OP_COMPUTE, Q_MAX, '0, '0);
        send_item(OP_COMPUTE, 32'sh7FFF_FFFE, '0, '0);
        wait_drain();
        apply_config(Q_MIN, Q_MAX, 32'h0000_0001, Q_MAX, Q_MIN, 32'h0000_0000);
        send_item(OP_COMPUTE, '0, '0, '0);
        send_item(OP_COMPUTE, Q_MIN, '0, '0);
        send_item(OP_COMPUTE, Q_MAX, '0, Q_MIN);
        wait_drain();
    endtask

    // Receiver stops for a long stretch while items keep coming, so the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = HOLD_CYCLES;
        send_random_item();
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_COMPUTE, rand_q16(), rand_q16(), rand_q16());
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_COMPUTE, rand_q16(), rand_q16(), rand_q16());
        send_item(OP_CLEAR, '0, '0, '0);
        wait_drain();
    endtask

    // Bursts of random items, each burst under a fresh register set.
    task automatic test_random_phase(int s_pct, int r_pct, int n_items);
        int sent;
        int burst;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items)
        begin
            wait_drain();
            randomize_config();
            burst = $urandom_range(10, 40);
            for (int i = 0; i < burst; i++)
            begin
                send_random_item();
                sent++;
            end
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        drive_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (clamped === 1'b1)
                clamped_seen++;
            if (result_q.size() == 0)
            begin
                note_mismatch("unexpected result, drive", 0, drive);
            end
            else
            begin
                want = result_q.pop_front();
                if (drive !== want.drive)
                    note_mismatch("drive", want.drive, drive);
                if (clamped !== want.clamped)
                    note_mismatch("clamped", want.clamped, clamped);
            end
        end
    end

    // Watchdog: end the run if no handshake completes for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        send_idle_pct = 22;
        recv_idle_pct = 60;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_dead_band_and_clamp();
        test_inverted_limits();
        test_extreme_config();
        test_backpressure();
        test_random_phase(22, 60, 350);
        test_random_phase(60, 22, 350);
        test_random_phase(0, 0, 350);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d items (%0d clears) under %0d register writes, three idling mixes.",
                 items_sent, clears_sent, cfg_writes);
        $display("Checked %0d results, %0d of them clamped; %0d mismatches.",
                 results_seen, clamped_seen, mismatch_cnt);
        if (mismatch_cnt == 0 && result_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
